// ===== hdl/life_pkg.sv =====
package life_pkg;

	localparam int GRID_SIZE_DEF = 64;
	localparam int COUNT_W       = 7;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

	// action codes
	localparam logic [1:0] ACT_WRITE   = 2'd0;
	localparam logic [1:0] ACT_ADVANCE = 2'd1;
	localparam logic [1:0] ACT_READ    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
	localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;

	typedef struct packed {
		logic [1:0] action;
		logic [5:0] row;
		logic [5:0] column;
		logic       cell_alive;
	} cmd_t;

	typedef struct packed {
		logic read_alive;
		logic range_error;
	} result_t;

endpackage

// ===== hdl/life_cellular_automaton_grid_core.sv =====
// Game of Life grid (B3/S23), one bit per cell, rows held in one synchronous row memory.
// A command is taken when start is high and busy is low; its result shows on result for
// exactly one cycle with done high, and cannot be held off, so sample it when done is set.
// From the accepting edge to the taking of the result: a cell write or read inside the
// configured area reads the row, then merges or picks the bit; an out-of-range write or
// read, an unused action code and an advance with a zero row count are answered from the
// idle state; an advance reads row 0, then row 1 in a priming state, then does one row read
// and one row write per cycle. A new command may be started in the cycle done is
// high. Cells outside the active area count as dead and keep their values across an advance.
// After reset the grid reads all dead at once: per-row valid flags mask rows never written,
// so there is no clearing pass. Configuration writes are taken whenever the block is idle.
module life_cellular_automaton_grid_core #(
	parameter int GRID_SIZE = life_pkg::GRID_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  life_pkg::cmd_t                command,
	output logic                          done,
	output life_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [life_pkg::COUNT_W-1:0]  cfg_data
);

	localparam int AW  = $clog2(GRID_SIZE);
	localparam int CW  = life_pkg::COUNT_W;
	localparam int CAP = (GRID_SIZE > 127) ? 127 : GRID_SIZE;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CELL  = 4'b0010,
		ST_PRIME = 4'b0100,
		ST_RUN   = 4'b1000
	} state_t;

	function automatic logic [AW-1:0] to_addr(logic [CW-1:0] v);
		logic [AW+CW-1:0] tmp;
		tmp = {{AW{1'b0}}, v};
		return tmp[AW-1:0];
	endfunction

	state_t                state_q;
	logic [CW-1:0]         row_cnt_q, col_cnt_q;
	logic [CW-1:0]         rows_act, cols_act;
	logic [1:0]            action_q;
	logic [AW-1:0]         row_addr_q;
	logic [AW-1:0]         col_idx_q;
	logic                  alive_q;
	logic [CW-1:0]         r_q;
	logic [GRID_SIZE-1:0]  prev_q, cur_q;
	logic [GRID_SIZE-1:0]  valid_q;
	logic                  done_q;
	life_pkg::result_t     result_q;

	logic [GRID_SIZE-1:0]  mem [GRID_SIZE];
	logic [GRID_SIZE-1:0]  rdata_s1;
	logic                  rvalid_s1;
	logic [GRID_SIZE-1:0]  rd_row;

	logic                  accept;
	logic                  in_area;
	logic                  re, we;
	logic [AW-1:0]         raddr, waddr;
	logic [GRID_SIZE-1:0]  wdata;
	logic [GRID_SIZE-1:0]  below, col_mask, new_row;
	logic [GRID_SIZE-1:0]  pa, pb, pd;
	logic                  last_row;

	assign rows_act = (row_cnt_q > CW'(CAP)) ? CW'(CAP) : row_cnt_q;
	assign cols_act = (col_cnt_q > CW'(CAP)) ? CW'(CAP) : col_cnt_q;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = !busy;
	assign done      = done_q;
	assign result    = result_q;

	assign in_area = ({1'b0, command.row} < rows_act) && ({1'b0, command.column} < cols_act);

	// rows never written read as dead
	assign rd_row   = rdata_s1 & {GRID_SIZE{rvalid_s1}};
	assign below    = ((r_q + 7'd1) < rows_act) ? rd_row : '0;
	assign last_row = ((r_q + 7'd1) == rows_act);

	// next generation of the current row, one lane per column
	always_comb begin
		logic [3:0] n;
		for (int i = 0; i < GRID_SIZE; i++) begin
			col_mask[i] = (32'(i) < 32'(cols_act));
		end
		pa = prev_q & col_mask;
		pb = cur_q & col_mask;
		pd = below & col_mask;
		for (int i = 0; i < GRID_SIZE; i++) begin
			n = {3'b0, pa[i]} + {3'b0, pd[i]};
			if (i > 0) begin
				n = n + {3'b0, pa[i-1]} + {3'b0, pb[i-1]} + {3'b0, pd[i-1]};
			end
			if (i < GRID_SIZE - 1) begin
				n = n + {3'b0, pa[i+1]} + {3'b0, pb[i+1]} + {3'b0, pd[i+1]};
			end
			new_row[i] = col_mask[i] ? ((n == 4'd3) || (pb[i] && (n == 4'd2))) : cur_q[i];
		end
	end

	// memory port control
	always_comb begin
		re    = 1'b0;
		we    = 1'b0;
		raddr = '0;
		waddr = '0;
		wdata = rd_row;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (command.action == life_pkg::ACT_ADVANCE) begin
						re    = (rows_act != '0);
						raddr = '0;
					end else begin
						re    = in_area && (command.action == life_pkg::ACT_WRITE
						        || command.action == life_pkg::ACT_READ);
						raddr = to_addr({1'b0, command.row});
					end
				end
			end
			ST_CELL: begin
				waddr = row_addr_q;
				wdata = rd_row;
				wdata[col_idx_q] = alive_q;
				we    = (action_q == life_pkg::ACT_WRITE);
			end
			ST_PRIME: begin
				re    = 1'b1;
				raddr = AW'(1);
			end
			ST_RUN: begin
				// row r+2 is read while row r is rewritten: never the same entry
				re    = 1'b1;
				raddr = to_addr(r_q + 7'd2);
				we    = 1'b1;
				waddr = to_addr(r_q);
				wdata = new_row;
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			row_cnt_q <= life_pkg::COUNT_RESET;
			col_cnt_q <= life_pkg::COUNT_RESET;
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
			done_q    <= 1'b0;
			r_q       <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					life_pkg::REG_ROW_COUNT:    row_cnt_q <= cfg_data;
					life_pkg::REG_COLUMN_COUNT: col_cnt_q <= cfg_data;
					default: ;
				endcase
			end
			if (re) begin
				rvalid_s1 <= valid_q[raddr];
			end
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (command.action) inside
							life_pkg::ACT_WRITE, life_pkg::ACT_READ: begin
								if (in_area) begin
									state_q <= ST_CELL;
								end else begin
									done_q <= 1'b1;
								end
							end
							life_pkg::ACT_ADVANCE: begin
								if (rows_act != '0) begin
									state_q <= ST_PRIME;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_CELL: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_PRIME: begin
					r_q     <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (last_row) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						r_q <= r_q + 7'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					action_q   <= command.action;
					row_addr_q <= to_addr({1'b0, command.row});
					col_idx_q  <= to_addr({1'b0, command.column});
					alive_q    <= command.cell_alive;
					prev_q     <= '0;
					result_q.read_alive  <= 1'b0;
					result_q.range_error <= !in_area && (command.action == life_pkg::ACT_WRITE
					                        || command.action == life_pkg::ACT_READ);
				end
			end
			ST_CELL: begin
				result_q.read_alive  <= (action_q == life_pkg::ACT_READ) && rd_row[col_idx_q];
				result_q.range_error <= 1'b0;
			end
			ST_PRIME: begin
				cur_q <= rd_row;
			end
			ST_RUN: begin
				prev_q <= cur_q;
				cur_q  <= below;
				result_q.read_alive  <= 1'b0;
				result_q.range_error <= 1'b0;
			end
			default: ;
		endcase
	end

endmodule
